// ----- src/lbpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Light bar pair matcher package
// Shared types, register indexes and fixed constants of the bar matcher.
// ----------------------------------------------------------------------------
package lbpm_pkg;

	// Store depth used as the default of the top level.
	localparam int SLOTS_DEFAULT = 16;

	// Field widths.
	localparam int COORD_W = 16;
	localparam int TILT_W  = 13;
	localparam int CFG_W   = 6;
	localparam int IDX_W   = 3;
	localparam int SLOT_OUT_W = 4;
	// Product of a 4-bit factor and a 16-bit length.
	localparam int PROD4_W = 20;
	// Product of a 6-bit factor and a 16-bit value.
	localparam int PROD6_W = 22;

	// Tilt window bounds, degrees with four fraction bits, all exclusive.
	localparam logic [TILT_W-1:0] TILT_A_LO = 13'd880;
	localparam logic [TILT_W-1:0] TILT_A_HI = 13'd2000;
	localparam logic [TILT_W-1:0] TILT_B_LO = 13'd3760;
	localparam logic [TILT_W-1:0] TILT_B_HI = 13'd4880;

	// Scale of the length tolerance, which is given in tenths.
	localparam logic [3:0] TENTHS_SCALE = 4'd10;

	// Register indexes of the configuration port.
	typedef enum logic [IDX_W-1:0] {
		REG_ASPECT_MIN   = 3'd0,
		REG_ASPECT_MAX   = 3'd1,
		REG_SPACING_MIN  = 3'd2,
		REG_SPACING_MAX  = 3'd3,
		REG_FLATNESS_MIN = 3'd4,
		REG_WIDTH_TOL    = 3'd5
	} cfg_reg_t;

	// One bar as kept in the store.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] len;
	} bar_t;

	// Bounds worked out once per new bar, plus the per-pair factors.
	typedef struct packed {
		logic [PROD4_W-1:0] spacing_lo;
		logic [PROD4_W-1:0] spacing_hi;
		logic [PROD4_W-1:0] ten_len;
		logic [PROD4_W-1:0] tol_len;
		logic [5:0]         flat_min;
		logic [3:0]         tol;
	} pair_limits_t;

endpackage
`default_nettype wire

// ----- src/lbpm_pair_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pair test unit
// Checks one stored bar against the new bar on spacing, flatness and length
// similarity, and forms the midpoint of the two centers.
// ----------------------------------------------------------------------------
module lbpm_pair_unit (
	input  wire lbpm_pkg::bar_t                 new_bar,
	input  wire lbpm_pkg::bar_t                 kept_bar,
	input  wire lbpm_pkg::pair_limits_t         limits,
	output logic                                match,
	output logic [lbpm_pkg::COORD_W-1:0]        mid_x,
	output logic [lbpm_pkg::COORD_W-1:0]        mid_y
);

	logic [lbpm_pkg::COORD_W-1:0] dx;
	logic [lbpm_pkg::COORD_W-1:0] dy;
	logic [lbpm_pkg::PROD6_W-1:0] flat_bound;
	logic [lbpm_pkg::PROD4_W-1:0] kept_tol;
	logic [lbpm_pkg::PROD4_W-1:0] kept_ten;
	logic [lbpm_pkg::COORD_W:0]   sum_x;
	logic [lbpm_pkg::COORD_W:0]   sum_y;
	logic                         spaced;
	logic                         flat;
	logic                         similar;

	// Absolute center distances.
	assign dx = (kept_bar.x > new_bar.x) ? kept_bar.x - new_bar.x : new_bar.x - kept_bar.x;
	assign dy = (kept_bar.y > new_bar.y) ? kept_bar.y - new_bar.y : new_bar.y - kept_bar.y;

	// Scaled bounds that depend on the stored bar.
	assign flat_bound = lbpm_pkg::PROD6_W'(limits.flat_min) * lbpm_pkg::PROD6_W'(dy);
	assign kept_tol   = lbpm_pkg::PROD4_W'(limits.tol) * lbpm_pkg::PROD4_W'(kept_bar.len);
	assign kept_ten   = lbpm_pkg::PROD4_W'(lbpm_pkg::TENTHS_SCALE)
		* lbpm_pkg::PROD4_W'(kept_bar.len);

	// The three tests, with every ratio cross multiplied.
	assign spaced  = (lbpm_pkg::PROD4_W'(dx) > limits.spacing_lo)
		&& (lbpm_pkg::PROD4_W'(dx) < limits.spacing_hi);
	assign flat    = (dy == '0) || (lbpm_pkg::PROD6_W'(dx) > flat_bound);
	assign similar = (limits.ten_len > kept_tol) && (limits.tol_len < kept_ten);
	assign match   = spaced && flat && similar;

	// Midpoint, rounded down.
	assign sum_x = {1'b0, new_bar.x} + {1'b0, kept_bar.x};
	assign sum_y = {1'b0, new_bar.y} + {1'b0, kept_bar.y};
	assign mid_x = sum_x[lbpm_pkg::COORD_W:1];
	assign mid_y = sum_y[lbpm_pkg::COORD_W:1];

endmodule
`default_nettype wire

// ----- src/light_bar_pair_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A rectangle taken in IDLE is screened in PREP; if it is a bar and the store is not
// empty, SCAN reads the kept bars slot by slot into the pair test and DRAIN tests the
// last one read; FINISH gives the status word. Pair words come earlier, one per
// matching slot. A new rectangle is taken only back in IDLE; the single pair test
// unit walks the bar store one slot a cycle. Reset empties the store and loads the
// register defaults; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Light bar pair matcher
// Screens rotated rectangles for light bars and pairs each new bar with the
// bars kept earlier in the frame, one stored bar per cycle.
// ----------------------------------------------------------------------------
module light_bar_pair_matcher #(
	parameter int SLOTS = lbpm_pkg::SLOTS_DEFAULT
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Configuration write port.
	input  wire                                 cfg_we,
	input  wire [lbpm_pkg::IDX_W-1:0]           cfg_index,
	input  wire [lbpm_pkg::CFG_W-1:0]           cfg_data,
	// Command side.
	input  wire                                 start,
	output logic                                busy,
	input  wire                                 new_frame,
	input  wire [lbpm_pkg::COORD_W-1:0]         center_x,
	input  wire [lbpm_pkg::COORD_W-1:0]         center_y,
	input  wire [lbpm_pkg::COORD_W-1:0]         bar_length,
	input  wire [lbpm_pkg::COORD_W-1:0]         bar_thickness,
	input  wire [lbpm_pkg::TILT_W-1:0]          tilt,
	// Result side.
	output logic                                result_strobe,
	output logic                                is_pair,
	output logic [lbpm_pkg::COORD_W-1:0]        mid_x,
	output logic [lbpm_pkg::COORD_W-1:0]        mid_y,
	output logic [lbpm_pkg::SLOT_OUT_W-1:0]     partner_slot,
	output logic                                accepted,
	output logic                                store_full,
	output logic                                last
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [5:0] aspect_min_q;
	logic [5:0] aspect_max_q;
	logic [3:0] spacing_min_q;
	logic [3:0] spacing_max_q;
	logic [5:0] flatness_min_q;
	logic [3:0] width_tol_q;

	// Current rectangle.
	lbpm_pkg::bar_t                cur_q;
	logic [lbpm_pkg::COORD_W-1:0]  thk_q;
	logic [lbpm_pkg::TILT_W-1:0]   tilt_q;
	logic                          acc_q;
	lbpm_pkg::pair_limits_t        limits_q;

	// Store bookkeeping and scan pointer.
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] idx_q;
	logic              scan_last;

	// Bar store and its registered read port.
	lbpm_pkg::bar_t    kept_q [SLOTS];
	lbpm_pkg::bar_t    rd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              valid_s1;

	// Screening of the current rectangle.
	logic                         tilt_ok;
	logic                         acc_c;
	logic [lbpm_pkg::PROD6_W-1:0] aspect_lo;
	logic [lbpm_pkg::PROD6_W-1:0] aspect_hi;
	logic                         full_c;

	// Pair unit outputs.
	logic                         pair_match;
	logic [lbpm_pkg::COORD_W-1:0] pair_mid_x;
	logic [lbpm_pkg::COORD_W-1:0] pair_mid_y;

	// Registered result word.
	logic                                strobe_q;
	logic                                is_pair_q;
	logic [lbpm_pkg::COORD_W-1:0]        mid_x_q;
	logic [lbpm_pkg::COORD_W-1:0]        mid_y_q;
	logic [lbpm_pkg::SLOT_OUT_W-1:0]     slot_q;
	logic                                accepted_q;
	logic                                full_q;
	logic                                last_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aspect_min_q   <= 6'd4;
			aspect_max_q   <= 6'd15;
			spacing_min_q  <= 4'd2;
			spacing_max_q  <= 4'd6;
			flatness_min_q <= 6'd4;
			width_tol_q    <= 4'd9;
		end else if (cfg_we) begin
			unique case (lbpm_pkg::cfg_reg_t'(cfg_index))
				lbpm_pkg::REG_ASPECT_MIN:   aspect_min_q   <= cfg_data;
				lbpm_pkg::REG_ASPECT_MAX:   aspect_max_q   <= cfg_data;
				lbpm_pkg::REG_SPACING_MIN:  spacing_min_q  <= cfg_data[3:0];
				lbpm_pkg::REG_SPACING_MAX:  spacing_max_q  <= cfg_data[3:0];
				lbpm_pkg::REG_FLATNESS_MIN: flatness_min_q <= cfg_data;
				lbpm_pkg::REG_WIDTH_TOL:    width_tol_q    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Tilt window and aspect test of the latched rectangle.
	assign tilt_ok = ((tilt_q > lbpm_pkg::TILT_A_LO) && (tilt_q < lbpm_pkg::TILT_A_HI))
		|| ((tilt_q > lbpm_pkg::TILT_B_LO) && (tilt_q < lbpm_pkg::TILT_B_HI));
	assign aspect_lo = lbpm_pkg::PROD6_W'(aspect_min_q) * lbpm_pkg::PROD6_W'(thk_q);
	assign aspect_hi = lbpm_pkg::PROD6_W'(aspect_max_q) * lbpm_pkg::PROD6_W'(thk_q);
	assign acc_c = tilt_ok && (thk_q != '0)
		&& (lbpm_pkg::PROD6_W'(cur_q.len) > aspect_lo)
		&& (lbpm_pkg::PROD6_W'(cur_q.len) < aspect_hi);

	assign full_c    = (count_q == CNT_FULL);
	assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// Store write at the end of an item and slot read during the scan.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && acc_q && !full_c) begin
			kept_q[count_q[SLOT_W-1:0]] <= cur_q;
		end
		rd_s1   <= kept_q[idx_q];
		slot_s1 <= idx_q;
	end

	lbpm_pair_unit u_pair (
		.new_bar  (cur_q),
		.kept_bar (rd_s1),
		.limits   (limits_q),
		.match    (pair_match),
		.mid_x    (pair_mid_x),
		.mid_y    (pair_mid_y)
	);

	// Sequencer with the result word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			acc_q      <= 1'b0;
			valid_s1   <= 1'b0;
			strobe_q   <= 1'b0;
			cur_q      <= '0;
			thk_q      <= '0;
			tilt_q     <= '0;
			limits_q   <= '0;
			is_pair_q  <= 1'b0;
			mid_x_q    <= '0;
			mid_y_q    <= '0;
			slot_q     <= '0;
			accepted_q <= 1'b0;
			full_q     <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			valid_s1 <= (state_q == ST_SCAN);

			// Pair words from the slot read in the previous cycle.
			priority if (valid_s1 && pair_match) begin
				strobe_q   <= 1'b1;
				is_pair_q  <= 1'b1;
				mid_x_q    <= pair_mid_x;
				mid_y_q    <= pair_mid_y;
				slot_q     <= lbpm_pkg::SLOT_OUT_W'(slot_s1);
				accepted_q <= 1'b1;
				full_q     <= 1'b0;
				last_q     <= 1'b0;
			end else if (state_q == ST_FINISH) begin
				strobe_q   <= 1'b1;
				is_pair_q  <= 1'b0;
				mid_x_q    <= '0;
				mid_y_q    <= '0;
				slot_q     <= '0;
				accepted_q <= acc_q;
				full_q     <= acc_q && full_c;
				last_q     <= 1'b1;
			end else begin
			end

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cur_q.x   <= center_x;
						cur_q.y   <= center_y;
						cur_q.len <= bar_length;
						thk_q     <= bar_thickness;
						tilt_q    <= tilt;
						if (new_frame) begin
							count_q <= '0;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					// Bounds that hold for the whole scan of this bar.
					acc_q <= acc_c;
					limits_q.spacing_lo <= lbpm_pkg::PROD4_W'(spacing_min_q)
						* lbpm_pkg::PROD4_W'(cur_q.len);
					limits_q.spacing_hi <= lbpm_pkg::PROD4_W'(spacing_max_q)
						* lbpm_pkg::PROD4_W'(cur_q.len);
					limits_q.ten_len <= lbpm_pkg::PROD4_W'(lbpm_pkg::TENTHS_SCALE)
						* lbpm_pkg::PROD4_W'(cur_q.len);
					limits_q.tol_len <= lbpm_pkg::PROD4_W'(width_tol_q)
						* lbpm_pkg::PROD4_W'(cur_q.len);
					limits_q.flat_min <= flatness_min_q;
					limits_q.tol      <= width_tol_q;
					idx_q <= '0;
					if (acc_c && count_q != '0) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + SLOT_W'(1);
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (acc_q && !full_c) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign is_pair       = is_pair_q;
	assign mid_x         = mid_x_q;
	assign mid_y         = mid_y_q;
	assign partner_slot  = slot_q;
	assign accepted      = accepted_q;
	assign store_full    = full_q;
	assign last          = last_q;

	// A status word closes the item, so the block is free when it shows.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |-> !busy)
		else $error("status word while the sequencer is still busy");

	// Pair words only appear while an item is being worked on.
	a_pair_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && is_pair |-> busy)
		else $error("pair word outside an item");

	// An accepted command always starts the sequencer.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not start the sequencer");

	// The fill count never passes the store depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("bar store count beyond its depth");

endmodule
`default_nettype wire

// ----- dv/light_bar_pair_matcher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light bar pair matcher testbench
// Offers rotated rectangles through the start/busy handshake and keeps its own
// model of the bar screen and the bar store. Every pair and status word that
// the block strobes out is checked field by field against that model (or the
// table, for typed rows). A short table of boundary rectangles runs first.
// Random frames under several register settings follow, with random sender gaps.
// ----------------------------------------------------------------------------
module light_bar_pair_matcher_tb;

	localparam int CYCLE_LIMIT  = 200000;
	// Longest gap from the last accepted rectangle to its status word, plus margin.
	localparam int QUIET_CYCLES = 24;
	// Indexes past the last register: writes to them must change nothing.
	localparam logic [lbpm_pkg::IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [lbpm_pkg::IDX_W-1:0] REG_SPARE_B = 3'd7;

	// One rectangle as offered to the block.
	typedef struct packed {
		logic                         new_frame;
		logic [lbpm_pkg::COORD_W-1:0] cx;
		logic [lbpm_pkg::COORD_W-1:0] cy;
		logic [lbpm_pkg::COORD_W-1:0] len;
		logic [lbpm_pkg::COORD_W-1:0] thk;
		logic [lbpm_pkg::TILT_W-1:0]  tilt;
	} rect_t;

	// One word on the result side.
	typedef struct packed {
		logic                            is_pair;
		logic [lbpm_pkg::COORD_W-1:0]    mid_x;
		logic [lbpm_pkg::COORD_W-1:0]    mid_y;
		logic [lbpm_pkg::SLOT_OUT_W-1:0] slot;
		logic                            accepted;
		logic                            store_full;
		logic                            last;
	} result_word_t;

	// Row of the boundary table. When typed is set, the status word is given
	// directly and no pair word may come.
	typedef struct packed {
		logic                         typed;
		logic                         t_acc;
		logic                         t_full;
		logic                         nf;
		logic [lbpm_pkg::COORD_W-1:0] cx;
		logic [lbpm_pkg::COORD_W-1:0] cy;
		logic [lbpm_pkg::COORD_W-1:0] len;
		logic [lbpm_pkg::COORD_W-1:0] thk;
		logic [lbpm_pkg::TILT_W-1:0]  tilt;
	} probe_row_t;

	// Boundary rectangles under the reset register values.
	localparam probe_row_t PROBES [19] = '{
		'{1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 13'd0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 13'd5759},
		'{1'b1, 1'b0, 1'b0, 1'b0, 16'd500, 16'd500, 16'd100, 16'd10, 13'd880},
		'{1'b1, 1'b0, 1'b0, 1'b0, 16'd500, 16'd500, 16'd100, 16'd10, 13'd2000},
		'{1'b1, 1'b0, 1'b0, 1'b0, 16'd500, 16'd500, 16'd100, 16'd10, 13'd3760},
		'{1'b1, 1'b0, 1'b0, 1'b0, 16'd500, 16'd500, 16'd100, 16'd10, 13'd4880},
		'{1'b1, 1'b0, 1'b0, 1'b0, 16'd500, 16'd500, 16'd100, 16'd0, 13'd1440},
		'{1'b1, 1'b0, 1'b0, 1'b0, 16'd500, 16'd500, 16'd40, 16'd10, 13'd1440},
		'{1'b1, 1'b0, 1'b0, 1'b0, 16'd500, 16'd500, 16'd150, 16'd10, 13'd1440},
		'{1'b1, 1'b1, 1'b0, 1'b1, 16'd1000, 16'd2000, 16'd41, 16'd10, 13'd881},
		'{1'b0, 1'b0, 1'b0, 1'b0, 16'd1150, 16'd2010, 16'd45, 16'd10, 13'd1999},
		'{1'b0, 1'b0, 1'b0, 1'b0, 16'd1300, 16'd2000, 16'd43, 16'd10, 13'd3761},
		'{1'b0, 1'b0, 1'b0, 1'b0, 16'd1450, 16'd2030, 16'd149, 16'd10, 13'd4879},
		'{1'b1, 1'b1, 1'b0, 1'b1, 16'd65535, 16'd65535, 16'd65535, 16'd4370, 13'd1440},
		'{1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd65000, 16'd4370, 13'd4000},
		'{1'b1, 1'b1, 1'b0, 1'b1, 16'd65535, 16'd65535, 16'd100, 16'd10, 13'd1440},
		'{1'b0, 1'b0, 1'b0, 1'b0, 16'd65235, 16'd65535, 16'd100, 16'd10, 13'd1440},
		'{1'b0, 1'b0, 1'b0, 1'b0, 16'd65235, 16'd65435, 16'd100, 16'd10, 13'd1440},
		'{1'b0, 1'b0, 1'b0, 1'b0, 16'd65135, 16'd65535, 16'd80, 16'd10, 13'd1440}
	};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [lbpm_pkg::IDX_W-1:0]      cfg_index;
	logic [lbpm_pkg::CFG_W-1:0]      cfg_data;
	logic                            start;
	logic                            busy;
	logic                            new_frame;
	logic [lbpm_pkg::COORD_W-1:0]    center_x;
	logic [lbpm_pkg::COORD_W-1:0]    center_y;
	logic [lbpm_pkg::COORD_W-1:0]    bar_length;
	logic [lbpm_pkg::COORD_W-1:0]    bar_thickness;
	logic [lbpm_pkg::TILT_W-1:0]     tilt;
	logic                            result_strobe;
	logic                            is_pair;
	logic [lbpm_pkg::COORD_W-1:0]    mid_x;
	logic [lbpm_pkg::COORD_W-1:0]    mid_y;
	logic [lbpm_pkg::SLOT_OUT_W-1:0] partner_slot;
	logic                            accepted;
	logic                            store_full;
	logic                            last;

	// Shadow copy of the registers.
	int unsigned lim_aspect_min;
	int unsigned lim_aspect_max;
	int unsigned lim_spacing_min;
	int unsigned lim_spacing_max;
	int unsigned lim_flat_min;
	int unsigned lim_tol;

	// Shadow copy of the bar store.
	int unsigned kept_px [lbpm_pkg::SLOTS_DEFAULT];
	int unsigned kept_py [lbpm_pkg::SLOTS_DEFAULT];
	int unsigned kept_len [lbpm_pkg::SLOTS_DEFAULT];
	int          kept_n;

	// Words worked out for the latest rectangle, and all words still owed.
	result_word_t fresh_words [$];
	result_word_t pending_words [$];

	int err_count;
	int rect_count;
	int setting_count;
	int pair_words;
	int status_words;
	int full_flags;
	int cycle_count;

	light_bar_pair_matcher u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.new_frame    (new_frame),
		.center_x     (center_x),
		.center_y     (center_y),
		.bar_length   (bar_length),
		.bar_thickness(bar_thickness),
		.tilt         (tilt),
		.result_strobe(result_strobe),
		.is_pair      (is_pair),
		.mid_x        (mid_x),
		.mid_y        (mid_y),
		.partner_slot (partner_slot),
		.accepted     (accepted),
		.store_full   (store_full),
		.last         (last)
	);

	always #10 clk = ~clk;

	// Register write as seen by the block: masked to width, spare indexes ignored.
	function automatic void shadow_reg_write(input logic [lbpm_pkg::IDX_W-1:0] idx,
			input logic [lbpm_pkg::CFG_W-1:0] data);
		case (lbpm_pkg::cfg_reg_t'(idx))
			lbpm_pkg::REG_ASPECT_MIN:   lim_aspect_min = data[5:0];
			lbpm_pkg::REG_ASPECT_MAX:   lim_aspect_max = data[5:0];
			lbpm_pkg::REG_SPACING_MIN:  lim_spacing_min = data[3:0];
			lbpm_pkg::REG_SPACING_MAX:  lim_spacing_max = data[3:0];
			lbpm_pkg::REG_FLATNESS_MIN: lim_flat_min = data[5:0];
			lbpm_pkg::REG_WIDTH_TOL:    lim_tol = data[3:0];
			default: ;
		endcase
	endfunction

	// Screens one rectangle and pairs it with the kept bars, slot by slot.
	// The words it causes land in fresh_words.
	function automatic void screen_and_match(input rect_t r);
		int unsigned dx;
		int unsigned dy;
		logic        tilt_ok;
		logic        is_bar;
		logic        spaced;
		logic        flat;
		logic        similar;
		logic        dropped;
		result_word_t w;
		fresh_words.delete();
		dropped = 1'b0;
		if (r.new_frame)
			kept_n = 0;
		tilt_ok = (r.tilt > lbpm_pkg::TILT_A_LO && r.tilt < lbpm_pkg::TILT_A_HI) ||
			(r.tilt > lbpm_pkg::TILT_B_LO && r.tilt < lbpm_pkg::TILT_B_HI);
		is_bar = tilt_ok && r.thk != 0 &&
			int'(r.len) > lim_aspect_min * r.thk && int'(r.len) < lim_aspect_max * r.thk;
		if (is_bar) begin
			for (int i = 0; i < kept_n; i++) begin
				dx = (kept_px[i] > r.cx) ? kept_px[i] - r.cx : r.cx - kept_px[i];
				dy = (kept_py[i] > r.cy) ? kept_py[i] - r.cy : r.cy - kept_py[i];
				spaced = dx > lim_spacing_min * r.len && dx < lim_spacing_max * r.len;
				flat = dy == 0 || dx > lim_flat_min * dy;
				similar = 10 * r.len > lim_tol * kept_len[i] &&
					lim_tol * r.len < 10 * kept_len[i];
				if (spaced && flat && similar) begin
					w = '0;
					w.is_pair = 1'b1;
					w.mid_x = lbpm_pkg::COORD_W'((r.cx + kept_px[i]) >> 1);
					w.mid_y = lbpm_pkg::COORD_W'((r.cy + kept_py[i]) >> 1);
					w.slot = lbpm_pkg::SLOT_OUT_W'(i);
					w.accepted = 1'b1;
					fresh_words = {fresh_words, w};
				end
			end
			if (kept_n < lbpm_pkg::SLOTS_DEFAULT) begin
				kept_px[kept_n] = r.cx;
				kept_py[kept_n] = r.cy;
				kept_len[kept_n] = r.len;
				kept_n++;
			end else begin
				dropped = 1'b1;
			end
		end
		w = '0;
		w.accepted = is_bar;
		w.store_full = dropped;
		w.last = 1'b1;
		fresh_words = {fresh_words, w};
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// Offers one rectangle and waits for the handshake. Start is left high so
	// that a following rectangle can go out back to back.
	task automatic offer_rect(input rect_t r, input bit typed, input result_word_t typed_word);
		start <= 1'b1;
		new_frame <= r.new_frame;
		center_x <= r.cx;
		center_y <= r.cy;
		bar_length <= r.len;
		bar_thickness <= r.thk;
		tilt <= r.tilt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		screen_and_match(r);
		if (typed)
			pending_words = {pending_words, typed_word};
		else
			pending_words = {pending_words, fresh_words};
		rect_count++;
	endtask

	// Holds the sender off until every owed word has come and the block is idle.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Write port drive; the caller lowers the write enable after its last write.
	task automatic write_reg(input logic [lbpm_pkg::IDX_W-1:0] idx,
			input logic [lbpm_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		shadow_reg_write(idx, data);
	endtask

	task automatic apply_setting(input int unsigned a_min, input int unsigned a_max,
			input int unsigned s_min, input int unsigned s_max,
			input int unsigned f_min, input int unsigned tol, input bit spare);
		wait_idle();
		write_reg(lbpm_pkg::REG_ASPECT_MIN, lbpm_pkg::CFG_W'(a_min));
		write_reg(lbpm_pkg::REG_ASPECT_MAX, lbpm_pkg::CFG_W'(a_max));
		write_reg(lbpm_pkg::REG_SPACING_MIN, lbpm_pkg::CFG_W'(s_min));
		write_reg(lbpm_pkg::REG_SPACING_MAX, lbpm_pkg::CFG_W'(s_max));
		write_reg(lbpm_pkg::REG_FLATNESS_MIN, lbpm_pkg::CFG_W'(f_min));
		write_reg(lbpm_pkg::REG_WIDTH_TOL, lbpm_pkg::CFG_W'(tol));
		if (spare) begin
			write_reg(REG_SPARE_A, lbpm_pkg::CFG_W'($urandom));
			write_reg(REG_SPARE_B, lbpm_pkg::CFG_W'($urandom));
		end
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	task automatic apply_random_setting();
		int unsigned a_min;
		int unsigned s_min;
		int unsigned s_max;
		a_min = $urandom_range(1, 6);
		s_min = $urandom_range(0, 3);
		s_max = s_min + $urandom_range(2, 8);
		if (s_max > 15)
			s_max = 15;
		apply_setting(a_min, a_min + $urandom_range(3, 20), s_min, s_max,
			$urandom_range(0, 10), $urandom_range(6, 10), 1'b0);
	endtask

	// Random frames. Most rectangles are bars laid out on a grid whose pitch
	// suits the spacing window, so that pairs and a full store come up often;
	// the rest are noise, mostly rejected.
	task automatic run_frames(input int quota, input bit idle_on);
		int          sent;
		int          frame_len;
		int unsigned base_len;
		int unsigned pitch;
		int unsigned x0;
		int unsigned y0;
		int unsigned len_v;
		int unsigned kdiv;
		int unsigned thk_v;
		rect_t       r;
		sent = 0;
		while (sent < quota) begin
			frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) :
				$urandom_range(1, 10);
			base_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1000, 4000) :
				$urandom_range(16, 400);
			pitch = base_len * (lim_spacing_min + lim_spacing_max) / 2 + 1;
			x0 = $urandom_range(0, 20000);
			y0 = $urandom_range(0, 60000);
			for (int k = 0; k < frame_len && sent < quota; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					r.new_frame = (k == 0) || ($urandom_range(0, 15) == 0);
					r.cx = lbpm_pkg::COORD_W'($urandom);
					r.cy = lbpm_pkg::COORD_W'($urandom);
					r.len = lbpm_pkg::COORD_W'($urandom);
					r.thk = ($urandom_range(0, 3) == 0) ? '0 : lbpm_pkg::COORD_W'($urandom);
					r.tilt = lbpm_pkg::TILT_W'($urandom_range(0, 5759));
				end else begin
					len_v = base_len + $urandom_range(0, base_len / 16);
					kdiv = (lim_aspect_max > lim_aspect_min + 1) ?
						$urandom_range(lim_aspect_min + 1, lim_aspect_max - 1) :
						lim_aspect_min + 1;
					thk_v = len_v / kdiv;
					if (thk_v == 0)
						thk_v = 1;
					r.new_frame = (k == 0);
					r.cx = lbpm_pkg::COORD_W'(x0 + $urandom_range(0, 5) * pitch);
					r.cy = lbpm_pkg::COORD_W'(y0 + $urandom_range(0, base_len / 8));
					r.len = lbpm_pkg::COORD_W'(len_v);
					r.thk = lbpm_pkg::COORD_W'(thk_v);
					r.tilt = $urandom_range(0, 1) ?
						lbpm_pkg::TILT_W'($urandom_range(881, 1999)) :
						lbpm_pkg::TILT_W'($urandom_range(3761, 4879));
				end
				if (idle_on && $urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 16)) @(posedge clk);
				end
				offer_rect(r, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// Every strobed word is checked against the oldest owed word.
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && result_strobe) begin
			if (pending_words.size() == 0) begin
				$error("result word arrived with no word expected");
				err_count++;
			end else begin
				want = pending_words.pop_front();
				compare_field("is_pair", want.is_pair, is_pair);
				compare_field("mid_x", want.mid_x, mid_x);
				compare_field("mid_y", want.mid_y, mid_y);
				compare_field("partner_slot", want.slot, partner_slot);
				compare_field("accepted", want.accepted, accepted);
				compare_field("store_full", want.store_full, store_full);
				compare_field("last", want.last, last);
			end
			if (is_pair)
				pair_words++;
			else
				status_words++;
			if (store_full)
				full_flags++;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Main sequence: reset, boundary table, random phases, final drain.
	initial begin
		rect_t        r;
		result_word_t tw;
		err_count = 0;
		rect_count = 0;
		setting_count = 0;
		pair_words = 0;
		status_words = 0;
		full_flags = 0;
		cycle_count = 0;
		kept_n = 0;
		shadow_reg_write(lbpm_pkg::REG_ASPECT_MIN, 6'd4);
		shadow_reg_write(lbpm_pkg::REG_ASPECT_MAX, 6'd15);
		shadow_reg_write(lbpm_pkg::REG_SPACING_MIN, 6'd2);
		shadow_reg_write(lbpm_pkg::REG_SPACING_MAX, 6'd6);
		shadow_reg_write(lbpm_pkg::REG_FLATNESS_MIN, 6'd4);
		shadow_reg_write(lbpm_pkg::REG_WIDTH_TOL, 6'd9);
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		start <= 1'b0;
		new_frame <= 1'b0;
		center_x <= '0;
		center_y <= '0;
		bar_length <= '0;
		bar_thickness <= '0;
		tilt <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Boundary table under the reset values, back to back.
		foreach (PROBES[i]) begin
			r.new_frame = PROBES[i].nf;
			r.cx = PROBES[i].cx;
			r.cy = PROBES[i].cy;
			r.len = PROBES[i].len;
			r.thk = PROBES[i].thk;
			r.tilt = PROBES[i].tilt;
			tw = '0;
			tw.accepted = PROBES[i].t_acc;
			tw.store_full = PROBES[i].t_full;
			tw.last = 1'b1;
			offer_rect(r, PROBES[i].typed, tw);
		end

		// Register settings: reset values, widest windows, values past the
		// register widths, tolerance of exactly ten, and random ones.
		apply_setting(4, 15, 2, 6, 4, 9, 1'b0);
		run_frames(35, 1'b1);
		apply_setting(0, 63, 0, 15, 0, 0, 1'b1);
		run_frames(35, 1'b1);
		apply_setting(63, 63, 63, 63, 63, 63, 1'b0);
		run_frames(12, 1'b1);
		apply_random_setting();
		run_frames(35, 1'b1);
		apply_setting(1, 40, 1, 12, 2, 10, 1'b1);
		run_frames(25, 1'b1);
		apply_random_setting();
		run_frames(35, 1'b1);
		// Closing stretch without sender gaps.
		apply_random_setting();
		run_frames(35, 1'b0);

		wait_idle();
		$display("Covered %0d rectangles under %0d register settings.",
			rect_count, setting_count + 1);
		$display("Checked %0d pair words and %0d status words, %0d with the store full.",
			pair_words, status_words, full_flags);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
